[design/aesr_pkg.sv]
package aesr_pkg;

	localparam logic [1:0] MODE_FULL = 2'd0;
	localparam logic [1:0] MODE_LAST = 2'd1;

	typedef logic [7:0] byte_t;
	typedef byte_t [15:0] block_t;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic byte_t xtime(byte_t v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

[design/aesr_pipe.sv]
// Three-stage round datapath with a pipeline-wide enable: S-box and ShiftRows,
// then MixColumns, then AddRoundKey.
module aesr_pipe import aesr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  logic [1:0]  mode,
	input  block_t      state_in,
	input  block_t      key_in,
	output logic        out_valid,
	output block_t      result
);
	logic   v_s1, v_s2, v_s3;
	logic   skip_s1, mix_s1;
	block_t st_s1, key_s1, st_s2, key_s2, st_s3;
	block_t sub, mixed;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sub[c*4+r] = SBOX[state_in[((c+r)%4)*4+r]];
			end
		end
	end

	always_comb begin
		byte_t a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = st_s1[c*4]; a1 = st_s1[c*4+1]; a2 = st_s1[c*4+2]; a3 = st_s1[c*4+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			mixed[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
			mixed[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
			mixed[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
			mixed[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s1 <= mode[1];
			mix_s1  <= (mode == MODE_FULL);
			st_s1   <= mode[1] ? state_in : sub;
			key_s1  <= key_in;
			st_s2   <= (mix_s1 && !skip_s1) ? mixed : st_s1;
			key_s2  <= key_s1;
			st_s3   <= st_s2 ^ key_s2;
		end
	end

	assign out_valid = v_s3;
	assign result    = st_s3;
endmodule

[design/aes_encrypt_round_top.sv]
// One AES encryption round per request, one request per cycle while not stalled.
// Stages run S-box/ShiftRows, then MixColumns, then AddRoundKey; the whole pipeline
// holds while a result waits, so throughput is one item per clock when the sink
// is ready. Mode 0 is a full round, mode 1 the last round, modes 2 and 3 apply
// the round key only. Bytes are column-major, byte 0 in the top of each high word.
module aes_encrypt_round_top import aesr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// mode[1:0], state_hi[65:2], state_lo[129:66], key_hi[193:130],
	// key_lo[257:194], zero fill
	input  logic [263:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_hi[63:0], result_lo[127:64]
	output logic [127:0] m_tdata
);
	block_t st, ky, res;
	logic   adv;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			st[i]   = s_tdata[2+56-8*i +: 8];
			st[i+8] = s_tdata[66+56-8*i +: 8];
			ky[i]   = s_tdata[130+56-8*i +: 8];
			ky[i+8] = s_tdata[194+56-8*i +: 8];
			m_tdata[56-8*i +: 8]    = res[i];
			m_tdata[64+56-8*i +: 8] = res[i+8];
		end
	end

	assign adv      = m_tready || !m_tvalid;
	assign s_tready = adv;

	aesr_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.mode     (s_tdata[1:0]),
		.state_in (st),
		.key_in   (ky),
		.out_valid(m_tvalid),
		.result   (res)
	);
endmodule

[verif/aes_encrypt_round_top_tb.sv]
`timescale 1ns / 1ps

module aes_encrypt_round_top_tb;
	import aesr_pkg::*;

	localparam logic [1:0] MODE_KEY_ONLY = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [63:0] key_lo;
		logic [63:0] key_hi;
		logic [63:0] state_lo;
		logic [63:0] state_hi;
		logic [1:0]  mode;
	} round_req_t;

	typedef struct packed {
		logic [63:0] result_lo;
		logic [63:0] result_hi;
	} round_out_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [263:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;

	round_req_t pending_reqs[$];
	round_out_t expected_states[$];
	int         mismatches;
	bit         in_taken;
	int         burst_left;
	int         gap_left;
	int         stall_phase;
	int         stall_period;

	aes_encrypt_round_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] gf_double(logic [7:0] v);
		logic [7:0] t;
		t = {v[6:0], 1'b0};
		if (v[7]) begin
			t = t ^ 8'h1b;
		end
		return t;
	endfunction

	function automatic round_out_t predict_round(round_req_t r);
		logic [7:0] s [16];
		logic [7:0] k [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		round_out_t o;
		for (int i = 0; i < 8; i++) begin
			s[i] = r.state_hi[63 - 8 * i -: 8];
			s[i + 8] = r.state_lo[63 - 8 * i -: 8];
			k[i] = r.key_hi[63 - 8 * i -: 8];
			k[i + 8] = r.key_lo[63 - 8 * i -: 8];
		end
		if (!r.mode[1]) begin
			// Substitution and row rotation: row r moves left by r columns.
			for (int c = 0; c < 4; c++) begin
				for (int rw = 0; rw < 4; rw++) begin
					t[c * 4 + rw] = SBOX[s[((c + rw) % 4) * 4 + rw]];
				end
			end
			for (int c = 0; c < 4; c++) begin
				if (r.mode == MODE_FULL) begin
					a0 = t[c * 4];
					a1 = t[c * 4 + 1];
					a2 = t[c * 4 + 2];
					a3 = t[c * 4 + 3];
					all = a0 ^ a1 ^ a2 ^ a3;
					s[c * 4] = a0 ^ all ^ gf_double(a0 ^ a1);
					s[c * 4 + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
					s[c * 4 + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
					s[c * 4 + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
				end else begin
					for (int rw = 0; rw < 4; rw++) begin
						s[c * 4 + rw] = t[c * 4 + rw];
					end
				end
			end
		end
		for (int i = 0; i < 8; i++) begin
			o.result_hi[63 - 8 * i -: 8] = s[i] ^ k[i];
			o.result_lo[63 - 8 * i -: 8] = s[i + 8] ^ k[i + 8];
		end
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic add_req(logic [1:0] mode, logic [63:0] sh, logic [63:0] sl,
			logic [63:0] kh, logic [63:0] kl);
		round_req_t r;
		r.mode = mode;
		r.state_hi = sh;
		r.state_lo = sl;
		r.key_hi = kh;
		r.key_lo = kl;
		pending_reqs.push_back(r);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// The ready seen at the falling edge can differ from the one at the accepting edge.
	always @(posedge clk) begin
		in_taken <= arst_n && s_tvalid && s_tready;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					s_tdata <= {6'd0, pending_reqs.pop_front()};
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver stalls on a rotating pattern whose period changes now and then.
	always @(negedge clk) begin
		if (arst_n) begin
			stall_phase <= (stall_phase + 1) % stall_period;
			if (stall_phase == 0 && $urandom_range(0, 15) == 0) begin
				stall_period <= $urandom_range(2, 11);
			end
			if (stall_period < 4) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= (stall_phase % stall_period) < stall_period - 3
					|| $urandom_range(0, 3) == 0;
			end
		end
	end

	always @(posedge clk) begin
		round_out_t got;
		round_out_t want;
		if (arst_n && s_tvalid && s_tready) begin
			expected_states.push_back(predict_round(round_req_t'(s_tdata[257:0])));
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = round_out_t'(m_tdata);
			if (expected_states.size() == 0) begin
				report_mismatch("unexpected result", got.result_hi, '0);
			end else begin
				want = expected_states.pop_front();
				if (got.result_hi !== want.result_hi) begin
					report_mismatch("result_hi", got.result_hi, want.result_hi);
				end
				if (got.result_lo !== want.result_lo) begin
					report_mismatch("result_lo", got.result_lo, want.result_lo);
				end
			end
		end
	end

	initial begin
		logic [63:0] sh, sl, kh, kl;
		int pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		in_taken = 1'b0;
		burst_left = 8;
		gap_left = 0;
		stall_phase = 0;
		stall_period = 1;

		// Directed: known vectors, field extremes, every mode including the unused one.
		add_req(MODE_FULL, 64'hd4bf5d30e0b452ae, 64'hb84111f11e2798e5, '0, '0);
		add_req(MODE_FULL, 64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808,
			64'ha0fafe1788542cb1, 64'h23a339392a6c7605);
		for (int m = 0; m < 4; m++) begin
			add_req(m[1:0], '0, '0, '0, '0);
			add_req(m[1:0], '1, '1, '1, '1);
			add_req(m[1:0], '1, '0, '0, '1);
			add_req(m[1:0], 64'h8080808080808080, 64'h0102040810204080,
				64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
			add_req(m[1:0], rand64(), rand64(), rand64(), rand64());
		end
		add_req(MODE_LAST, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
		add_req(MODE_KEY_ONLY, 64'h0123456789abcdef, 64'hfedcba9876543210, '1, '0);
		add_req(MODE_UNUSED, 64'h0123456789abcdef, 64'hfedcba9876543210, '0, '1);

		for (int n = 0; n < 1800; n++) begin
			pick = $urandom_range(0, 9);
			sh = rand64();
			sl = rand64();
			kh = rand64();
			kl = rand64();
			if (pick == 0) begin
				sh = '0;
				kl = '1;
			end else if (pick == 1) begin
				sl = '1;
				kh = '0;
			end
			add_req((pick < 5) ? MODE_FULL : 2'($urandom_range(0, 3)), sh, sl, kh, kl);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_reqs.size() == 0 && !s_tvalid);
		wait (expected_states.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
design/aesr_pkg.sv
design/aesr_pipe.sv
design/aes_encrypt_round_top.sv
verif/aes_encrypt_round_top_tb.sv
